// ----- sv/assert_macros.svh -----
// Assertion shorthands for the checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clk edge, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clk edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/lpg_pkg.sv -----
package lpg_pkg;

    localparam int COORD_W   = 7;
    localparam int ENDPT_W   = 8;
    localparam int ERR_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y = 1'd1;

    localparam logic [COORD_W-1:0] LIMIT_X_RST = 7'd127;
    localparam logic [COORD_W-1:0] LIMIT_Y_RST = 7'd63;

    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    typedef struct packed {
        action_t                    action;
        logic signed [ENDPT_W-1:0]  from_x;
        logic signed [ENDPT_W-1:0]  from_y;
        logic signed [ENDPT_W-1:0]  to_x;
        logic signed [ENDPT_W-1:0]  to_y;
    } cmd_t;

    typedef struct packed {
        logic               pixel_valid;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last;
    } pixel_t;

    // Clamp a signed endpoint coordinate to 0..lim
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [ENDPT_W-1:0] v,
        input logic [COORD_W-1:0]        lim
    );
        logic [COORD_W-1:0] res;
        if (v[ENDPT_W-1])
            res = '0;
        else if (v[COORD_W-1:0] > lim)
            res = lim;
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

endpackage

// ----- sv/line_pixel_generator.sv -----
// Line pixel generator: walks a straight line between two endpoints with the
// all-octant Bresenham error term and hands out one pixel per request.
// cmd channel (valid/ready): action start loads from_x/from_y/to_x/to_y and
// yields the first pixel; action advance yields the next pixel of the line.
// A start with both columns <= 0 or both rows <= 0 is rejected. Every request
// gives exactly one result; pixel_valid is 0 (other fields 0) for a rejected
// start or an advance with no active line. last marks the line's endpoint.
// Endpoints clamp to 0..limit_x / 0..limit_y, written on the cfg port (index 0
// limit_x, index 1 limit_y). The user must write them only while no request is
// in flight; the block does not enforce it. An accepted request passes through
// an input register, then one pass of the step logic into the result register
// that drives result_valid.
// Throughput: one request per cycle while result_ready is high; the error-term
// update that each request feeds back into the line state is combinational.
// If result_ready is low, the result register holds, the next request waits
// in the input register and cmd_ready drops only when both are full.
// Reset clears the line state and both stage valids; limits return to 127/63.
module line_pixel_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpg_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  lpg_pkg::cmd_t                 cmd,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lpg_pkg::pixel_t               result
);
    import lpg_pkg::*;

    logic   cmd_valid_reg;
    cmd_t   cmd_reg;
    logic   result_valid_reg;
    pixel_t result_reg;
    pixel_t step_pixel;
    logic   advance;

    // move the held request into the result register when it has room
    assign advance   = cmd_valid_reg && (!result_valid_reg || result_ready);
    assign cmd_ready = !cmd_valid_reg || advance;

    lpg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .cmd       (cmd_reg),
        .pixel     (step_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
                cmd_valid_reg <= cmd_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            cmd_reg <= cmd;
        if (advance)
            result_reg <= step_pixel;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/lpg_core.sv -----
module lpg_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpg_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          fire,
    input  lpg_pkg::cmd_t                 cmd,
    output lpg_pkg::pixel_t               pixel
);
    import lpg_pkg::*;

    logic [COORD_W-1:0]       limit_x_reg, limit_y_reg;
    logic                     busy_reg, busy_next;
    logic [COORD_W-1:0]       cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]       end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic                     step_left_reg, step_left_next, step_up_reg, step_up_next;
    logic [COORD_W-1:0]       span_x_reg, span_x_next;
    logic signed [ENDPT_W-1:0] neg_span_y_reg, neg_span_y_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;

    // start-time values
    logic                      is_start, line_ok;
    logic [COORD_W-1:0]        s_cx, s_cy, s_ex, s_ey;
    logic signed [ENDPT_W-1:0] dx, dy, ndx;
    logic [COORD_W-1:0]        s_span;
    logic signed [ENDPT_W-1:0] s_nsy;
    logic signed [ERR_W-1:0]   s_err;

    // operands of the pixel step
    logic [COORD_W-1:0]        cx, cy, ex, ey, sx;
    logic                      left, up;
    logic signed [ENDPT_W-1:0] nsy;
    logic signed [ERR_W-1:0]   err, nsy_e, sx_e, add_x, add_y, err_step;
    logic signed [ERR_W:0]     de, nsy_w, sx_w;
    logic                      x_hit, y_hit, stop_x, stop, x_move, y_move, emit;

    assign is_start = fire && (cmd.action == ACT_START);
    assign line_ok  = ((cmd.from_y > 0) || (cmd.to_y > 0)) &&
                      ((cmd.from_x > 0) || (cmd.to_x > 0));

    assign s_cx = clamp_coord(cmd.from_x, limit_x_reg);
    assign s_cy = clamp_coord(cmd.from_y, limit_y_reg);
    assign s_ex = clamp_coord(cmd.to_x, limit_x_reg);
    assign s_ey = clamp_coord(cmd.to_y, limit_y_reg);

    assign dx     = $signed({1'b0, s_ex}) - $signed({1'b0, s_cx});
    assign dy     = $signed({1'b0, s_ey}) - $signed({1'b0, s_cy});
    assign ndx    = -dx;
    assign s_span = dx[ENDPT_W-1] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    assign s_nsy  = dy[ENDPT_W-1] ? dy : -dy;
    assign s_err  = $signed({{(ERR_W-COORD_W){1'b0}}, s_span}) +
                    $signed({{(ERR_W-ENDPT_W){s_nsy[ENDPT_W-1]}}, s_nsy});

    // on start, step from the freshly loaded line
    assign cx   = is_start ? s_cx : cur_x_reg;
    assign cy   = is_start ? s_cy : cur_y_reg;
    assign ex   = is_start ? s_ex : end_x_reg;
    assign ey   = is_start ? s_ey : end_y_reg;
    assign sx   = is_start ? s_span : span_x_reg;
    assign nsy  = is_start ? s_nsy : neg_span_y_reg;
    assign left = is_start ? dx[ENDPT_W-1] : step_left_reg;
    assign up   = is_start ? dy[ENDPT_W-1] : step_up_reg;
    assign err  = is_start ? s_err : err_reg;

    assign de    = {err, 1'b0};
    assign nsy_w = $signed({{(ERR_W+1-ENDPT_W){nsy[ENDPT_W-1]}}, nsy});
    assign sx_w  = $signed({{(ERR_W+1-COORD_W){1'b0}}, sx});
    assign nsy_e = $signed({{(ERR_W-ENDPT_W){nsy[ENDPT_W-1]}}, nsy});
    assign sx_e  = $signed({{(ERR_W-COORD_W){1'b0}}, sx});

    assign x_hit  = (de >= nsy_w);
    assign stop_x = x_hit && (cx == ex);
    assign x_move = x_hit && !stop_x;
    assign y_hit  = !stop_x && (de <= sx_w);
    assign stop   = stop_x || (y_hit && (cy == ey));
    assign y_move = y_hit && (cy != ey);

    assign add_x    = x_move ? nsy_e : '0;
    assign add_y    = y_move ? sx_e : '0;
    assign err_step = err + add_x + add_y;

    assign emit = is_start ? line_ok : (fire && busy_reg);

    always_comb
    begin
        pixel = '0;
        if (emit)
        begin
            pixel.pixel_valid = 1'b1;
            pixel.pixel_x     = cx;
            pixel.pixel_y     = cy;
            pixel.last        = stop;
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        step_left_next  = step_left_reg;
        step_up_next    = step_up_reg;
        span_x_next     = span_x_reg;
        neg_span_y_next = neg_span_y_reg;
        err_next        = err_reg;
        if (is_start && !line_ok)
            busy_next = 1'b0;
        else if (emit)
        begin
            end_x_next      = ex;
            end_y_next      = ey;
            step_left_next  = left;
            step_up_next    = up;
            span_x_next     = sx;
            neg_span_y_next = nsy;
            busy_next       = !stop;
            // on the final pixel keep the position, drop the pending move
            cur_x_next = cx;
            cur_y_next = cy;
            err_next   = err;
            if (!stop)
            begin
                if (x_move)
                    cur_x_next = left ? cx - 1'b1 : cx + 1'b1;
                if (y_move)
                    cur_y_next = up ? cy - 1'b1 : cy + 1'b1;
                err_next = err_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg    <= LIMIT_X_RST;
            limit_y_reg    <= LIMIT_Y_RST;
            busy_reg       <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            step_left_reg  <= 1'b0;
            step_up_reg    <= 1'b0;
            span_x_reg     <= '0;
            neg_span_y_reg <= '0;
            err_reg        <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_LIMIT_X))
                limit_x_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_LIMIT_Y))
                limit_y_reg <= cfg_data;
            busy_reg       <= busy_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            step_left_reg  <= step_left_next;
            step_up_reg    <= step_up_next;
            span_x_reg     <= span_x_next;
            neg_span_y_reg <= neg_span_y_next;
            err_reg        <= err_next;
        end
    end

endmodule

// ----- sv/lpg_checker.sv -----
`include "assert_macros.svh"

module lpg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_ready,
    input logic             result_valid,
    input logic             result_ready,
    input lpg_pkg::pixel_t  result
);
    logic stalled;
    logic empty_res;

    assign stalled   = result_valid && !result_ready;
    assign empty_res = result_valid && !result.pixel_valid;

    // a stalled result holds
    `ASSERT_CLK(a_result_hold, stalled |=> result_valid && $stable(result), "result not held")

    // an empty result carries no coordinates
    `ASSERT_CLK(a_empty_zero, empty_res |-> result == '0, "empty result has nonzero fields")

    // last only on a given pixel
    `ASSERT_NEVER(a_last_valid, empty_res && result.last, "last set on an empty result")

    // back-pressure only when the result side is stalled
    `ASSERT_CLK(a_ready_stall, !cmd_ready |-> stalled, "cmd_ready low without a stalled result")

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);
